>>> rtl/tilt_angle_to_hue_assert.svh
// Assertion macros shared by the tilt-angle-to-hue RTL.
// Expects clk_i and rst_ni in scope wherever TATH_ASSERT is used.
`ifndef TILT_ANGLE_TO_HUE_ASSERT_SVH
`define TILT_ANGLE_TO_HUE_ASSERT_SVH

`ifndef SYNTHESIS
`define TATH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TATH_ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) prop) else $error(msg);
`else
`define TATH_ASSERT(lbl, prop, msg)
`define TATH_ASSERT_CLK(lbl, clk, rst, prop, msg)
`endif

`endif

>>> rtl/tath_pkg.sv
// Package for the tilt-angle-to-hue block: default sizes and the CORDIC
// arctangent table. No dependencies.
`default_nettype none

package tath_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned AngleBitsDefault   = 16;
  localparam int unsigned AtanTableLen       = 24;
  localparam int unsigned AccelW             = 16;
  localparam int unsigned HueW               = 8;
  // Datapath: sensor counts with 16 fraction bits, room for the quarter
  // turn and the CORDIC gain of about 1.65.
  localparam int unsigned DataW              = 35;

  // atan(2^-i) with a full turn equal to 2^32
  localparam logic [31:0] AtanTurn32 [AtanTableLen] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // Table entry rounded to a full turn of 2^angle_bits.
  function automatic logic [31:0] atan_entry(int unsigned idx, int unsigned angle_bits);
    logic [63:0] t;
    t = {32'd0, AtanTurn32[idx]};
    t = (t + (64'd1 << (31 - angle_bits))) >> (32 - angle_bits);
    return t[31:0];
  endfunction

endpackage

`default_nettype wire

>>> rtl/tilt_angle_to_hue.sv
// Tilt-angle-to-hue: one CORDIC iteration per pipeline stage, then a
// clamp-and-scale stage into the output register.
// An accepted word passes the entry, CORDIC stage and output registers.
// Throughput: one word per cycle; the whole pipe advances together
// whenever the output register is empty or being drained.
// Reset: rst_ni clears every stage valid bit and the output valid only.
`default_nettype none

`include "tilt_angle_to_hue_assert.svh"

module tilt_angle_to_hue
  import tath_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault,
  parameter int unsigned ANGLE_BITS   = AngleBitsDefault
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic signed [AccelW-1:0] accel_y_i,
  input  wire logic signed [AccelW-1:0] accel_z_i,
  input  wire logic                     read_failed_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [HueW-1:0]               hue_o
);

  // Number of CORDIC stages; the table covers at most AtanTableLen.
  localparam int unsigned NumStg = (CORDIC_STEPS < AtanTableLen) ? CORDIC_STEPS
                                                                  : AtanTableLen;
  // Angle accumulator: one sign bit and one bit of headroom over half a turn.
  localparam int unsigned AngW   = ANGLE_BITS + 2;
  localparam int unsigned OffW   = ANGLE_BITS + 1;
  localparam int unsigned ProdW  = ANGLE_BITS + HueW + 1;

  localparam logic signed [AngW-1:0] Half    = AngW'(64'd1 << (ANGLE_BITS - 1));
  localparam logic signed [AngW-1:0] Quarter = AngW'(64'd1 << (ANGLE_BITS - 2));
  localparam logic [OffW-1:0]        FullOff = OffW'(64'd1 << ANGLE_BITS);

  // Stage registers; index k holds the vector before iteration k.
  logic                    valid_q [NumStg+1];
  logic signed [DataW-1:0] x_q     [NumStg+1];
  logic signed [DataW-1:0] y_q     [NumStg+1];
  logic signed [AngW-1:0]  ang_q   [NumStg+1];
  logic                    fail_q  [NumStg+1];
  logic                    yzero_q [NumStg+1];
  logic                    zneg_q  [NumStg+1];

  logic            out_valid_q;
  logic [HueW-1:0] hue_q;
  logic [HueW-1:0] hue_d;

  // Advance every stage at once when the output slot frees up.
  logic advance;
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // ---------------------------------------------------------------------
  // Entry: scale by 2^16 and fold the left half plane into the right.
  // ---------------------------------------------------------------------
  logic signed [DataW-1:0] x_in, y_in, x_rot, y_rot;
  logic signed [AngW-1:0]  ang_rot;

  always_comb begin
    x_in    = DataW'(signed'({accel_z_i, 16'h0000}));
    y_in    = DataW'(signed'({accel_y_i, 16'h0000}));
    x_rot   = x_in;
    y_rot   = y_in;
    ang_rot = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        // rotate by -90 degrees
        x_rot   = y_in;
        y_rot   = -x_in;
        ang_rot = Quarter;
      end else begin
        // rotate by +90 degrees
        x_rot   = -y_in;
        y_rot   = x_in;
        ang_rot = -Quarter;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (advance) begin
      valid_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      x_q[0]     <= x_rot;
      y_q[0]     <= y_rot;
      ang_q[0]   <= ang_rot;
      fail_q[0]  <= read_failed_i;
      yzero_q[0] <= (accel_y_i == '0);
      zneg_q[0]  <= accel_z_i[AccelW-1];
    end
  end

  // ---------------------------------------------------------------------
  // CORDIC vectoring: drive y toward zero, accumulate the turned angle.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < NumStg; k++) begin : g_stage
    localparam logic signed [AngW-1:0] Entry = AngW'(atan_entry(k, ANGLE_BITS));

    logic signed [DataW-1:0] xs, ys, x_d, y_d;
    logic signed [AngW-1:0]  ang_d;

    always_comb begin
      xs = x_q[k] >>> k;
      ys = y_q[k] >>> k;
      if (y_q[k] >= 0) begin
        x_d   = x_q[k] + ys;
        y_d   = y_q[k] - xs;
        ang_d = ang_q[k] + Entry;
      end else begin
        x_d   = x_q[k] - ys;
        y_d   = y_q[k] + xs;
        ang_d = ang_q[k] - Entry;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (advance) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        x_q[k+1]     <= x_d;
        y_q[k+1]     <= y_d;
        ang_q[k+1]   <= ang_d;
        fail_q[k+1]  <= fail_q[k];
        yzero_q[k+1] <= yzero_q[k];
        zneg_q[k+1]  <= zneg_q[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output: exact angle on the Y = 0 axis, offset by half a turn, clamp
  // to 0..full turn, scale by 255 and drop ANGLE_BITS bits; zero on a failed read.
  // ---------------------------------------------------------------------
  logic signed [AngW-1:0] ang_sel, off_s;
  logic [OffW-1:0]        off_c;
  logic [ProdW-1:0]       prod;

  always_comb begin
    if (yzero_q[NumStg]) begin
      ang_sel = zneg_q[NumStg] ? Half : '0;
    end else begin
      ang_sel = ang_q[NumStg];
    end
    off_s = ang_sel + Half;
    if (off_s < 0) begin
      off_c = '0;
    end else if (off_s > signed'(AngW'(FullOff))) begin
      off_c = FullOff;
    end else begin
      off_c = off_s[OffW-1:0];
    end
    // off * 255 as (off << 8) - off
    prod  = (ProdW'(off_c) << HueW) - ProdW'(off_c);
    hue_d = fail_q[NumStg] ? '0 : prod[ANGLE_BITS +: HueW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= valid_q[NumStg];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      hue_q <= hue_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hue_o       = hue_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `TATH_ASSERT(a_fail_gives_zero,
    valid_q[NumStg] && fail_q[NumStg] && advance |=> out_valid_o && (hue_o == '0),
    "failed read did not give hue zero")
  `TATH_ASSERT(a_origin_gives_mid,
    valid_q[NumStg] && !fail_q[NumStg] && yzero_q[NumStg] && !zneg_q[NumStg] && advance
      |=> hue_o == HueW'(127),
    "zero Y with nonnegative Z did not give hue 127")
  `TATH_ASSERT(a_entry_travels,
    valid_q[0] && advance |=> valid_q[1],
    "word lost between entry and first CORDIC stage")

endmodule

`default_nettype wire

>>> test/hue_checker.sv
// Checker for tilt_angle_to_hue: predicts the hue of every accepted word
// with a CORDIC atan2 of its own and compares it with the block's output.
// Depends on tath_pkg for the port widths and the arctangent table.
module hue_checker
  import tath_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDefault,
  parameter int unsigned ANGLE_BITS   = AngleBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic signed [AccelW-1:0] accel_y_i,
  input  logic signed [AccelW-1:0] accel_z_i,
  input  logic                     read_failed_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [HueW-1:0]          hue_i,
  output int                       pending_o,
  output int                       fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HueW-1:0] hue_expected_q[$];
  logic [HueW-1:0] hue_want;
  int              hue_errors = 0;
  int              hue_words  = 0;

  // Roll angle as a binary angle (full turn = 2^ANGLE_BITS), offset by half
  // a turn, clamped and scaled onto 0..255.
  function automatic logic [HueW-1:0] roll_hue(logic signed [AccelW-1:0] ay,
                                              logic signed [AccelW-1:0] az,
                                              logic failed);
    longint half;
    longint quarter;
    longint x;
    longint y;
    longint t;
    longint xs;
    longint ys;
    longint step_ang;
    longint ang;
    longint off;
    longint scaled;
    half    = longint'(1) << (ANGLE_BITS - 1);
    quarter = longint'(1) << (ANGLE_BITS - 2);
    if (failed) return '0;
    if (ay == 0) begin
      ang = (az >= 0) ? 0 : half;
    end else begin
      x   = longint'(az) * 65536;
      y   = longint'(ay) * 65536;
      ang = 0;
      // Left half plane: turn a quarter into the right half first.
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x   = y;
          y   = -t;
          ang = quarter;
        end else begin
          x   = -y;
          y   = t;
          ang = -quarter;
        end
      end
      for (int i = 0; i < CORDIC_STEPS && i < AtanTableLen; i++) begin
        step_ang = longint'({32'd0, AtanTurn32[i]});
        step_ang = (step_ang + (longint'(1) << (31 - ANGLE_BITS))) >>> (32 - ANGLE_BITS);
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x   = x + ys;
          y   = y - xs;
          ang = ang + step_ang;
        end else begin
          x   = x - ys;
          y   = y + xs;
          ang = ang - step_ang;
        end
      end
    end
    off = ang + half;
    if (off < 0) off = 0;
    if (off > (longint'(1) << ANGLE_BITS)) off = longint'(1) << ANGLE_BITS;
    scaled = (off * 255) >>> ANGLE_BITS;
    return scaled[HueW-1:0];
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        hue_expected_q.push_back(roll_hue(accel_y_i, accel_z_i, read_failed_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (hue_expected_q.size() == 0) begin
          hue_errors++;
          if (hue_errors <= 10) begin
            $display("hue word %0d: none expected, got %0d", hue_words, hue_i);
          end
        end else begin
          hue_want = hue_expected_q.pop_front();
          if (hue_i !== hue_want) begin
            hue_errors++;
            if (hue_errors <= 10) begin
              $display("hue word %0d: expected %0d, got %0d", hue_words, hue_want, hue_i);
            end
          end
        end
        hue_words++;
      end
    end
    pending_o    <= hue_expected_q.size();
    fail_count_o <= hue_errors;
  end

endmodule

>>> test/tb_top.sv
// Top of the tilt_angle_to_hue testbench: clock, reset, directed and random
// sample words, receiver back-pressure, and the verdict.
// Depends on tath_pkg, the tilt_angle_to_hue RTL and hue_checker.
module tb_top
  import tath_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CordicSteps = CordicStepsDefault;
  localparam int unsigned AngleBits   = AngleBitsDefault;
  localparam int          ClkPeriod   = 10;
  localparam int          RandWords   = 400;
  localparam int          HoldOffAt   = 120;   // result count that triggers the long stall
  localparam int          HoldOffLen  = 400;
  localparam int          CycleLimit  = 200000;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic signed [AccelW-1:0] accel_y     = '0;
  logic signed [AccelW-1:0] accel_z     = '0;
  logic                     read_failed = 1'b0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [HueW-1:0]          hue;

  int pending;
  int fail_count;
  int cycles      = 0;
  int sent        = 0;
  int received    = 0;
  bit send_burst  = 1'b0;
  bit recv_burst  = 1'b0;

  tilt_angle_to_hue #(
    .CORDIC_STEPS(CordicSteps),
    .ANGLE_BITS  (AngleBits)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .accel_y_i    (accel_y),
    .accel_z_i    (accel_z),
    .read_failed_i(read_failed),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .hue_o        (hue)
  );

  hue_checker #(
    .CORDIC_STEPS(CordicSteps),
    .ANGLE_BITS  (AngleBits)
  ) i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .accel_y_i    (accel_y),
    .accel_z_i    (accel_z),
    .read_failed_i(read_failed),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .hue_i        (hue),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  // Watchdog: end the run if the block stops making progress.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tilt_angle_to_hue: mismatch");
      $finish;
    end
  end

  // Offer one sample word after a random gap and hold it until accepted.
  // Called at a rising edge; returns at the edge that accepts the word.
  task automatic send_sample(input logic signed [AccelW-1:0] y,
                             input logic signed [AccelW-1:0] z,
                             input logic failed);
    int gap;
    // Switch between idling and back-to-back stretches every 40 words.
    if (sent % 40 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    accel_y     <= y;
    accel_z     <= z;
    read_failed <= failed;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // Draw one random word. Bias toward the axes, small vectors and failed
  // reads so that the sign and quadrant cases come up often.
  task automatic send_random_sample();
    int                       kind;
    logic signed [AccelW-1:0] y;
    logic signed [AccelW-1:0] z;
    logic                     failed;
    kind   = $urandom_range(0, 99);
    y      = AccelW'($urandom);
    z      = AccelW'($urandom);
    failed = 1'b0;
    if (kind < 10) begin
      failed = 1'b1;
    end else if (kind < 22) begin
      y = '0;
    end else if (kind < 32) begin
      z = '0;
    end else if (kind < 45) begin
      y = AccelW'($urandom_range(0, 16) - 8);
    end else if (kind < 55) begin
      y = AccelW'($urandom_range(0, 16) - 8);
      z = AccelW'($urandom_range(0, 16) - 8);
    end else if (kind < 62) begin
      // Near the negative Z axis: the angle lands close to +-pi.
      y = AccelW'($urandom_range(0, 64) - 32);
      z = -$signed(16'($urandom_range(16384, 32768)));
    end
    send_sample(y, z, failed);
  endtask

  // Receiver: random stall per result, burst stretches, and one long hold-off
  // so the pipe fills up and pushes back on the sender.
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (received % 40 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 14);
      if (received == HoldOffAt) stall = HoldOffLen;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      received++;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Failed reads: hue is zero whatever the sample.
    send_sample(16'sh0000, 16'sh0000, 1'b1);
    send_sample(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_sample(-16'sh8000, -16'sh8000, 1'b1);
    send_sample(16'sh1234, -16'sh4321, 1'b1);
    // Zero Y: exact angle, zero or half a turn.
    send_sample(16'sh0000, 16'sh0000, 1'b0);
    send_sample(16'sh0000, 16'sh7FFF, 1'b0);
    send_sample(16'sh0000, -16'sh0001, 1'b0);
    send_sample(16'sh0000, -16'sh8000, 1'b0);
    // Zero Z: quarter turns.
    send_sample(16'sh7FFF, 16'sh0000, 1'b0);
    send_sample(-16'sh8000, 16'sh0000, 1'b0);
    send_sample(16'sh0001, 16'sh0000, 1'b0);
    // Extremes in each quadrant.
    send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, -16'sh8000, 1'b0);
    send_sample(-16'sh8000, -16'sh8000, 1'b0);
    // Negative Z near the axis: the residual may overshoot pi and clamp.
    send_sample(16'sh0001, -16'sh8000, 1'b0);
    send_sample(-16'sh0001, -16'sh8000, 1'b0);
    send_sample(16'sh0001, -16'sh0001, 1'b0);
    send_sample(-16'sh0001, -16'sh0001, 1'b0);
    send_sample(-16'sh8000, -16'sh0001, 1'b0);
    // Small vectors.
    send_sample(16'sh0001, 16'sh0001, 1'b0);
    send_sample(-16'sh0001, 16'sh0001, 1'b0);

    repeat (RandWords) send_random_sample();
    in_valid <= 1'b0;

    // Drain: wait for every expected hue, then let the pipe settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (CordicSteps + 4) @(posedge clk);

    if (fail_count == 0) begin
      $display("tilt_angle_to_hue: match");
    end else begin
      $display("tilt_angle_to_hue: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/tath_pkg.sv
rtl/tilt_angle_to_hue.sv
test/hue_checker.sv
test/tb_top.sv
